// File: sv/sesi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesi_pkg
// shared constants, codes and types of the session second indexer
// ----------------------------------------------------------------------------
package sesi_pkg;

  localparam int MAX_INTERVALS = 8;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

  localparam int SEC_W  = 17;  // seconds of day as appended or parsed
  localparam int T_W    = 19;  // seconds on the placed timeline
  localparam int SIDX_W = 18;  // saturating session offset
  localparam int OUT_W  = 19;  // signed session index port

  localparam logic [T_W-1:0]    DAY_SEC     = T_W'(86400);
  localparam logic [T_W-1:0]    TWO_DAY_SEC = T_W'(2 * 86400);
  localparam logic [SEC_W-1:0]  HOUR_SEC    = SEC_W'(3600);
  localparam logic [SEC_W-1:0]  MIN_SEC     = SEC_W'(60);
  localparam logic [7:0]        ASCII_ZERO  = 8'd48;
  localparam logic [SIDX_W-1:0] IDX_MAX     = '1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2
  } sesi_op_t;

  // query token handed from cell to cell
  typedef struct packed {
    logic [T_W-1:0]    t;
    logic [SIDX_W-1:0] sum;
    logic [SIDX_W-1:0] idx;
    logic              hit;
  } sesi_tok_t;

  // table status seen by every cell
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] wrap_pos;
    logic             wrapped;
  } sesi_ctrl_t;

  // table write into one cell
  typedef struct packed {
    logic             we;
    logic [SEC_W-1:0] start_sec;
    logic [SEC_W-1:0] end_sec;
  } sesi_wr_t;

endpackage
`default_nettype wire

// File: sv/session_second_indexer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// session_second_indexer_core
// interval table of trading sessions with wrap handling and time lookup
// ----------------------------------------------------------------------------
// One transaction is worked on at a time and each gives exactly one result.
// Append, clear and the unused opcode pass from acceptance through the done
// state to a result in the output register. A query passes through the idle
// state, which takes the text, the parse state, which checks and converts the
// digits, the adjust state, which places the time on the wrapped timeline,
// the scan state, as the query token walks the chain of table cells, and the
// done state, which loads the result; a bad time or an empty table skips the
// scan. A new transaction is taken as soon as a result sits in the output
// register, even while it still waits to be taken. After reset the table is
// empty; no clearing pass is run.
// ----------------------------------------------------------------------------
module session_second_indexer_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_opcode,
  input  wire logic [sesi_pkg::SEC_W-1:0]          in_start_sec,
  input  wire logic [sesi_pkg::SEC_W-1:0]          in_end_sec,
  input  wire logic [63:0]                         in_time_text,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [sesi_pkg::OUT_W-1:0]        out_session_index,
  output logic                                     out_in_session,
  output logic                                     out_time_valid,
  output logic                                     out_load_error
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PARSE  = 5'b00010,
    ST_ADJUST = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_DONE   = 5'b10000
  } sesi_state_t;

  sesi_state_t                 state_r;
  logic [sesi_pkg::CNT_W-1:0]  count_r, wrap_pos_r, scan_cnt_r;
  logic                        wrapped_r;
  logic [sesi_pkg::SEC_W-1:0]  last_end_r, first_start_r;
  logic [63:0]                 text_r;
  logic                        time_ok_r;
  logic [sesi_pkg::SEC_W-1:0]  time_sec_r;
  logic                        from_scan_r, res_valid_r, res_err_r;
  sesi_pkg::sesi_tok_t         tok0_r;

  logic                               out_valid_r, out_hit_r, out_tvalid_r, out_err_r;
  logic signed [sesi_pkg::OUT_W-1:0]  out_idx_r;

  logic                        in_fire, out_free;
  logic                        time_ok;
  logic [sesi_pkg::SEC_W-1:0]  time_sec;
  logic                        full, bad_order, wrap_seen, append_err, append_ok;
  logic                        move_back;
  logic [sesi_pkg::T_W-1:0]    placed_t;
  sesi_pkg::sesi_ctrl_t        ctrl;
  sesi_pkg::sesi_wr_t          wr [sesi_pkg::MAX_INTERVALS];
  sesi_pkg::sesi_tok_t         tok [sesi_pkg::MAX_INTERVALS + 1];

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  sesi_time_parse u_parse (
    .time_text (text_r),
    .time_ok   (time_ok),
    .time_sec  (time_sec)
  );

  // append checks against the previous end, kept beside the table
  assign full       = (count_r >= sesi_pkg::CNT_W'(sesi_pkg::MAX_INTERVALS));
  assign bad_order  = (in_start_sec >= in_end_sec);
  assign wrap_seen  = (count_r != '0) && (in_start_sec < last_end_r);
  assign append_err = full || bad_order || (wrap_seen && wrapped_r);
  assign append_ok  = in_fire && (in_opcode == sesi_pkg::OP_APPEND) && !append_err;

  // after a wrap a time past the last end goes back a day when nearer the first start
  always_comb begin
    move_back = (time_sec_r > last_end_r) &&
                ({1'b0, time_sec_r, 1'b0} >
                 ((sesi_pkg::SEC_W + 2)'(first_start_r) + (sesi_pkg::SEC_W + 2)'(last_end_r)));
    if (!wrapped_r) begin
      placed_t = sesi_pkg::T_W'(time_sec_r);
    end else if (move_back) begin
      placed_t = sesi_pkg::T_W'(time_sec_r) + sesi_pkg::DAY_SEC;
    end else begin
      placed_t = sesi_pkg::T_W'(time_sec_r) + sesi_pkg::TWO_DAY_SEC;
    end
  end

  assign ctrl.count    = count_r;
  assign ctrl.wrap_pos = wrap_pos_r;
  assign ctrl.wrapped  = wrapped_r;
  assign tok[0]        = tok0_r;

  for (genvar gi = 0; gi < sesi_pkg::MAX_INTERVALS; gi++) begin : g_cell
    assign wr[gi].we        = append_ok && (count_r == sesi_pkg::CNT_W'(gi));
    assign wr[gi].start_sec = in_start_sec;
    assign wr[gi].end_sec   = in_end_sec;

    sesi_cell u_cell (
      .clk      (clk),
      .cell_idx (sesi_pkg::CNT_W'(gi)),
      .ctrl     (ctrl),
      .wr       (wr[gi]),
      .tok_in   (tok[gi]),
      .tok_out  (tok[gi+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      wrap_pos_r  <= '0;
      wrapped_r   <= 1'b0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a result loaded in the same cycle keeps the flag high
      if (out_valid_r && out_ready && !((state_r == ST_DONE) && out_free)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            text_r      <= in_time_text;
            from_scan_r <= 1'b0;
            res_valid_r <= 1'b0;
            res_err_r   <= 1'b0;
            state_r     <= ST_DONE;
            unique case (in_opcode)
              sesi_pkg::OP_APPEND: begin
                res_err_r <= append_err;
                if (!append_err) begin
                  count_r    <= count_r + sesi_pkg::CNT_W'(1);
                  last_end_r <= in_end_sec;
                  if (count_r == '0) begin
                    first_start_r <= in_start_sec;
                  end
                  if (wrap_seen) begin
                    wrapped_r  <= 1'b1;
                    wrap_pos_r <= count_r;
                  end
                end
              end
              sesi_pkg::OP_CLEAR: begin
                count_r    <= '0;
                wrap_pos_r <= '0;
                wrapped_r  <= 1'b0;
              end
              sesi_pkg::OP_QUERY: begin
                state_r <= ST_PARSE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PARSE: begin
          time_ok_r  <= time_ok;
          time_sec_r <= time_sec;
          state_r    <= ST_ADJUST;
        end
        ST_ADJUST: begin
          res_valid_r <= time_ok_r;
          if (!time_ok_r || (count_r == '0)) begin
            state_r <= ST_DONE;
          end else begin
            tok0_r.t    <= placed_t;
            tok0_r.sum  <= '0;
            tok0_r.idx  <= '0;
            tok0_r.hit  <= 1'b0;
            from_scan_r <= 1'b1;
            scan_cnt_r  <= '0;
            state_r     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_cnt_r <= scan_cnt_r + sesi_pkg::CNT_W'(1);
          if (scan_cnt_r == sesi_pkg::CNT_W'(sesi_pkg::MAX_INTERVALS - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded as the transaction leaves the done state
  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_hit_r    <= from_scan_r && tok[sesi_pkg::MAX_INTERVALS].hit;
      out_tvalid_r <= res_valid_r;
      out_err_r    <= res_err_r;
      if (from_scan_r && tok[sesi_pkg::MAX_INTERVALS].hit) begin
        out_idx_r <= {1'b0, tok[sesi_pkg::MAX_INTERVALS].idx};
      end else begin
        out_idx_r <= '1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_session_index = out_idx_r;
  assign out_in_session    = out_hit_r;
  assign out_time_valid    = out_tvalid_r;
  assign out_load_error    = out_err_r;

endmodule
`default_nettype wire

// File: sv/sesi_time_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesi_time_parse
// checks the digits of an HH:MM:SS text and converts it to seconds of day
// ----------------------------------------------------------------------------
module sesi_time_parse (
  input  wire logic [63:0]               time_text,
  output logic                           time_ok,
  output logic [sesi_pkg::SEC_W-1:0]     time_sec
);

  logic [7:0] h0, h1, m0, m1, s0, s1;
  logic       hour_ok, min_ok, sec_ok;
  logic [3:0] h0_d, h1_d, m0_d, m1_d, s0_d, s1_d;
  logic [sesi_pkg::SEC_W-1:0] hours, mins, secs;

  assign h0 = time_text[63:56];
  assign h1 = time_text[55:48];
  assign m0 = time_text[39:32];
  assign m1 = time_text[31:24];
  assign s0 = time_text[15:8];
  assign s1 = time_text[7:0];

  // separators are not checked; 24 hours and 60 minutes or seconds are allowed
  assign hour_ok = (h1 >= sesi_pkg::ASCII_ZERO) &&
                   (((h0 >= sesi_pkg::ASCII_ZERO) && (h0 <= sesi_pkg::ASCII_ZERO + 8'd1) &&
                     (h1 <= sesi_pkg::ASCII_ZERO + 8'd9)) ||
                    ((h0 == sesi_pkg::ASCII_ZERO + 8'd2) && (h1 <= sesi_pkg::ASCII_ZERO + 8'd4)));

  assign min_ok = ((m0 >= sesi_pkg::ASCII_ZERO) && (m0 <= sesi_pkg::ASCII_ZERO + 8'd5) &&
                   (m1 >= sesi_pkg::ASCII_ZERO) && (m1 <= sesi_pkg::ASCII_ZERO + 8'd9)) ||
                  ((m0 == sesi_pkg::ASCII_ZERO + 8'd6) && (m1 == sesi_pkg::ASCII_ZERO));

  assign sec_ok = ((s0 >= sesi_pkg::ASCII_ZERO) && (s0 <= sesi_pkg::ASCII_ZERO + 8'd5) &&
                   (s1 >= sesi_pkg::ASCII_ZERO) && (s1 <= sesi_pkg::ASCII_ZERO + 8'd9)) ||
                  ((s0 == sesi_pkg::ASCII_ZERO + 8'd6) && (s1 == sesi_pkg::ASCII_ZERO));

  assign time_ok = hour_ok && min_ok && sec_ok;

  assign h0_d = 4'(h0 - sesi_pkg::ASCII_ZERO);
  assign h1_d = 4'(h1 - sesi_pkg::ASCII_ZERO);
  assign m0_d = 4'(m0 - sesi_pkg::ASCII_ZERO);
  assign m1_d = 4'(m1 - sesi_pkg::ASCII_ZERO);
  assign s0_d = 4'(s0 - sesi_pkg::ASCII_ZERO);
  assign s1_d = 4'(s1 - sesi_pkg::ASCII_ZERO);

  always_comb begin
    hours    = sesi_pkg::SEC_W'(h0_d) * sesi_pkg::SEC_W'(10) + sesi_pkg::SEC_W'(h1_d);
    mins     = sesi_pkg::SEC_W'(m0_d) * sesi_pkg::SEC_W'(10) + sesi_pkg::SEC_W'(m1_d);
    secs     = sesi_pkg::SEC_W'(s0_d) * sesi_pkg::SEC_W'(10) + sesi_pkg::SEC_W'(s1_d);
    time_sec = time_ok ? (hours * sesi_pkg::HOUR_SEC + mins * sesi_pkg::MIN_SEC + secs) : '0;
  end

endmodule
`default_nettype wire

// File: sv/sesi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesi_cell
// one table entry; tests the passing query token against its interval
// ----------------------------------------------------------------------------
module sesi_cell (
  input  wire logic                        clk,
  input  wire logic [sesi_pkg::CNT_W-1:0]  cell_idx,
  input  wire sesi_pkg::sesi_ctrl_t        ctrl,
  input  wire sesi_pkg::sesi_wr_t          wr,
  input  wire sesi_pkg::sesi_tok_t         tok_in,
  output sesi_pkg::sesi_tok_t              tok_out
);

  logic [sesi_pkg::SEC_W-1:0]  start_r, end_r;
  sesi_pkg::sesi_tok_t         tok_r, tok_nxt;
  logic [sesi_pkg::T_W-1:0]    day_off, pos_a, pos_b, t_off;
  logic [sesi_pkg::SIDX_W-1:0] span;
  logic [sesi_pkg::SIDX_W:0]   sum_ext;
  logic [sesi_pkg::T_W:0]      idx_ext;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      start_r <= wr.start_sec;
      end_r   <= wr.end_sec;
    end
  end

  always_comb begin
    // entries before the wrap point lie one day back
    if (!ctrl.wrapped) begin
      day_off = '0;
    end else if (cell_idx < ctrl.wrap_pos) begin
      day_off = sesi_pkg::DAY_SEC;
    end else begin
      day_off = sesi_pkg::TWO_DAY_SEC;
    end
    pos_a   = sesi_pkg::T_W'(start_r) + day_off;
    pos_b   = sesi_pkg::T_W'(end_r) + day_off;
    t_off   = tok_in.t - pos_a;
    span    = sesi_pkg::SIDX_W'(end_r - start_r) + sesi_pkg::SIDX_W'(1);
    sum_ext = (sesi_pkg::SIDX_W + 1)'(tok_in.sum) + (sesi_pkg::SIDX_W + 1)'(span);
    idx_ext = (sesi_pkg::T_W + 1)'(tok_in.sum) + (sesi_pkg::T_W + 1)'(t_off);

    tok_nxt = tok_in;
    if (!tok_in.hit && (cell_idx < ctrl.count)) begin
      if ((tok_in.t >= pos_a) && (tok_in.t <= pos_b)) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.idx = (idx_ext > (sesi_pkg::T_W + 1)'(sesi_pkg::IDX_MAX)) ?
                      sesi_pkg::IDX_MAX : sesi_pkg::SIDX_W'(idx_ext);
      end else begin
        tok_nxt.sum = (sum_ext > (sesi_pkg::SIDX_W + 1)'(sesi_pkg::IDX_MAX)) ?
                      sesi_pkg::IDX_MAX : sesi_pkg::SIDX_W'(sum_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// File: test/session_lookup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_lookup_checker
// watches both channels of the session second indexer, keeps its own copy of
// the interval table, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module session_lookup_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [1:0]                         in_opcode,
  input  wire logic [sesi_pkg::SEC_W-1:0]         in_start_sec,
  input  wire logic [sesi_pkg::SEC_W-1:0]         in_end_sec,
  input  wire logic [63:0]                        in_time_text,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic signed [sesi_pkg::OUT_W-1:0]  out_session_index,
  input  wire logic                               out_in_session,
  input  wire logic                               out_time_valid,
  input  wire logic                               out_load_error,
  output int                                      pending_count,
  output int                                      error_count,
  output int                                      hit_count,
  output int                                      reject_count
);
  import sesi_pkg::*;

  localparam longint DAY_S       = 86400;
  localparam longint OFFSET_CEIL = 262143;

  typedef struct packed {
    logic [OUT_W-1:0] index;
    logic             hit;
    logic             valid;
    logic             err;
  } lookup_t;

  logic [SEC_W-1:0] tbl_start [MAX_INTERVALS];
  logic [SEC_W-1:0] tbl_end   [MAX_INTERVALS];
  int               tbl_count;
  int               tbl_wrap_pos;
  bit               tbl_wrapped;
  lookup_t          queued_lookups [$];

  // entry position on the timeline once a wrap has been seen
  function automatic longint placed_sec(logic [SEC_W-1:0] raw, int i);
    longint v;
    v = longint'(raw);
    if (tbl_wrapped) v += (i < tbl_wrap_pos) ? DAY_S : 2 * DAY_S;
    return v;
  endfunction

  function automatic bit sixty_ok(int hi, int lo);
    return (hi >= 0 && hi <= 5 && lo >= 0 && lo <= 9) || (hi == 6 && lo == 0);
  endfunction

  function automatic bit decode_clock(logic [63:0] text, output longint secs);
    int d [8];
    bit ok;
    for (int p = 0; p < 8; p++) d[p] = int'(text[63 - 8 * p -: 8]) - 48;
    ok = d[1] >= 0 && ((d[0] >= 0 && d[0] <= 1 && d[1] <= 9) || (d[0] == 2 && d[1] <= 4));
    ok = ok && sixty_ok(d[3], d[4]) && sixty_ok(d[6], d[7]);
    secs = ok ? longint'((10 * d[0] + d[1]) * 3600 + (10 * d[3] + d[4]) * 60 +
                         10 * d[6] + d[7]) : 0;
    return ok;
  endfunction

  // applies one transaction to the table copy and returns its result
  function automatic lookup_t step_table(logic [1:0] op, logic [SEC_W-1:0] start_s,
                                         logic [SEC_W-1:0] end_s, logic [63:0] text);
    lookup_t r;
    longint t, t1, t2, a, b, sum, idx;
    int last;
    r.index = '1;
    r.hit   = 1'b0;
    r.valid = 1'b0;
    r.err   = 1'b0;
    case (op)
      OP_APPEND: begin
        if (tbl_count >= MAX_INTERVALS || start_s >= end_s) begin
          r.err = 1'b1;
        end else if (tbl_count > 0) begin
          if (start_s < tbl_end[tbl_count - 1]) begin
            if (tbl_wrapped) begin
              r.err = 1'b1;
            end else begin
              tbl_wrapped  = 1'b1;
              tbl_wrap_pos = tbl_count;
            end
          end
        end
        if (!r.err) begin
          tbl_start[tbl_count] = start_s;
          tbl_end[tbl_count]   = end_s;
          tbl_count++;
        end
      end
      OP_CLEAR: begin
        tbl_count    = 0;
        tbl_wrap_pos = 0;
        tbl_wrapped  = 1'b0;
      end
      OP_QUERY: begin
        if (decode_clock(text, t)) begin
          r.valid = 1'b1;
          if (tbl_count > 0) begin
            last = tbl_count - 1;
            if (tbl_wrapped) begin
              t += 2 * DAY_S;
              t2 = placed_sec(tbl_end[last], last);
              if (t > t2) begin
                t1 = placed_sec(tbl_start[0], 0);
                // closer to the first session of the next cycle: one day back
                if (t - t2 > t1 - t + DAY_S) t -= DAY_S;
              end
            end
            sum = 0;
            for (int i = 0; i < tbl_count && !r.hit; i++) begin
              a = placed_sec(tbl_start[i], i);
              b = placed_sec(tbl_end[i], i);
              if (t >= a && t <= b) begin
                idx = sum + (t - a);
                if (idx > OFFSET_CEIL) idx = OFFSET_CEIL;
                r.index = idx[OUT_W-1:0];
                r.hit   = 1'b1;
              end else begin
                sum += (b - a) + 1;
                if (sum > OFFSET_CEIL) sum = OFFSET_CEIL;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      tbl_count    = 0;
      tbl_wrap_pos = 0;
      tbl_wrapped  = 1'b0;
      queued_lookups.delete();
      pending_count <= 0;
      error_count   <= 0;
      hit_count     <= 0;
      reject_count  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        want = step_table(in_opcode, in_start_sec, in_end_sec, in_time_text);
        queued_lookups = {queued_lookups, want};
        hit_count    <= hit_count + int'(want.hit);
        reject_count <= reject_count + int'(want.err);
      end
      if (out_valid && out_ready) begin
        if (queued_lookups.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, got index %0d",
                   $time, out_session_index);
          bad++;
        end else begin
          want = queued_lookups.pop_front();
          if (out_session_index !== want.index) begin
            $display("%0t: session_index expected %0d, got %0d",
                     $time, $signed(want.index), out_session_index);
            bad++;
          end
          if (out_in_session !== want.hit) begin
            $display("%0t: in_session expected %0b, got %0b", $time, want.hit, out_in_session);
            bad++;
          end
          if (out_time_valid !== want.valid) begin
            $display("%0t: time_valid expected %0b, got %0b",
                     $time, want.valid, out_time_valid);
            bad++;
          end
          if (out_load_error !== want.err) begin
            $display("%0t: load_error expected %0b, got %0b",
                     $time, want.err, out_load_error);
            bad++;
          end
        end
      end
      error_count   <= error_count + bad;
      pending_count <= queued_lookups.size();
    end
  end

endmodule

// File: test/session_second_indexer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_second_indexer_core_test
// drives appends, clears and clock-text lookups into the session indexer with
// bursty input and a stalling output; the checker beside the block scores it
// ----------------------------------------------------------------------------
module session_second_indexer_core_test;
  import sesi_pkg::*;

  localparam int         LONG_HOLD     = 80;
  localparam int         IDLE_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         RANDOM_ITEMS  = 500;
  localparam int         LAST_SEC      = 90060;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic [1:0]              in_opcode    = OP_CLEAR;
  logic [SEC_W-1:0]        in_start_sec = '0;
  logic [SEC_W-1:0]        in_end_sec   = '0;
  logic [63:0]             in_time_text = '0;
  logic                    out_ready    = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_session_index;
  logic                    out_in_session;
  logic                    out_time_valid;
  logic                    out_load_error;

  int pending_count, error_count, hit_count, reject_count;

  // stimulus side
  int burst_left    = 0;
  bit steady_sender = 1'b0;
  int n_append      = 0;
  int n_clear       = 0;
  int n_query       = 0;
  int n_ignored     = 0;

  // receiver side
  logic hold_go     = 1'b0;
  bit   hold_taken  = 1'b0;
  int   hold_left   = 0;
  int   rx_mode     = 0;
  int   rx_run_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  session_second_indexer_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_start_sec      (in_start_sec),
    .in_end_sec        (in_end_sec),
    .in_time_text      (in_time_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_session_index (out_session_index),
    .out_in_session    (out_in_session),
    .out_time_valid    (out_time_valid),
    .out_load_error    (out_load_error)
  );

  session_lookup_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_start_sec      (in_start_sec),
    .in_end_sec        (in_end_sec),
    .in_time_text      (in_time_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_session_index (out_session_index),
    .out_in_session    (out_in_session),
    .out_time_valid    (out_time_valid),
    .out_load_error    (out_load_error),
    .pending_count     (pending_count),
    .error_count       (error_count),
    .hit_count         (hit_count),
    .reject_count      (reject_count)
  );

  // output stalls: one long hold on request, otherwise random stretches of four ready patterns
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_run_left == 0) begin
        rx_mode     <= $urandom_range(0, 3);
        rx_run_left <= $urandom_range(5, 40);
      end else begin
        rx_run_left <= rx_run_left - 1;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int rand_sec();
    return $urandom_range(0, LAST_SEC);
  endfunction

  function automatic logic [63:0] rand_text();
    return {$urandom, $urandom};
  endfunction

  // HH:MM:SS text; separators are mostly a colon, sometimes a random byte, which the block ignores
  function automatic logic [63:0] clock_text(int h, int m, int s);
    logic [7:0] sep;
    sep = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h3A;
    return {ASCII_ZERO + 8'(h / 10), ASCII_ZERO + 8'(h % 10), sep,
            ASCII_ZERO + 8'(m / 10), ASCII_ZERO + 8'(m % 10), sep,
            ASCII_ZERO + 8'(s / 10), ASCII_ZERO + 8'(s % 10)};
  endfunction

  function automatic logic [63:0] sec_text(int sec);
    int h, m, s;
    if (sec < 0) sec = 0;
    h = sec / 3600;
    m = (sec % 3600) / 60;
    s = sec % 60;
    // same instant written with a sixty field
    if ($urandom_range(0, 3) == 0) begin
      if (s == 0 && m > 0) begin
        m--;
        s = 60;
      end else if (m == 0 && h > 0) begin
        h--;
        m = 60;
      end
    end
    return clock_text(h, m, s);
  endfunction

  task automatic send_item(input logic [1:0] op, input int start_s, input int end_s,
                           input logic [63:0] text);
    int gap;
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_start_sec <= SEC_W'(start_s);
    in_end_sec   <= SEC_W'(end_s);
    in_time_text <= text;
    do @(posedge clk); while (!in_ready);
    case (op)
      OP_APPEND: n_append++;
      OP_CLEAR:  n_clear++;
      OP_QUERY:  n_query++;
      default:   n_ignored++;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = steady_sender ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // one trading day: clear, build a table (maybe across midnight), then look up times
  task automatic run_session();
    int n, wrap_at, cursor, start_s, end_s, j, sec, p;
    int sess_start [MAX_INTERVALS];
    int sess_end   [MAX_INTERVALS];
    logic [63:0] text;
    steady_sender = ($urandom_range(0, 3) == 0);
    send_item(OP_CLEAR, rand_sec(), rand_sec(), rand_text());
    n       = $urandom_range(1, MAX_INTERVALS);
    wrap_at = (n > 1 && $urandom_range(0, 2) != 0) ? $urandom_range(1, n - 1) : 0;
    cursor  = (wrap_at > 0) ? $urandom_range(40000, 55000) : $urandom_range(0, 30000);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i == wrap_at) begin
        // past midnight: start below the previous end
        start_s = $urandom_range(0, (sess_end[i-1] > 15000) ? 15000 : sess_end[i-1] - 1);
      end else begin
        start_s = (i == 0) ? cursor : cursor + $urandom_range(0, 1500);
      end
      end_s = start_s + (($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 3000));
      if (start_s > LAST_SEC) start_s = LAST_SEC;
      if (end_s > LAST_SEC) end_s = LAST_SEC;
      sess_start[i] = start_s;
      sess_end[i]   = end_s;
      send_item(OP_APPEND, start_s, end_s, rand_text());
      // zero gap puts a start right on the previous end, which is no wrap
      cursor = end_s + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000));
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          start_s = rand_sec();
          send_item(OP_APPEND, start_s, $urandom_range(0, start_s), rand_text());
        end
        1: send_item(OP_APPEND, 0, $urandom_range(1, 500), rand_text());
        default: begin
          repeat (MAX_INTERVALS) begin
            send_item(OP_APPEND, cursor, cursor + 10, rand_text());
            cursor += 20;
          end
        end
      endcase
    end
    repeat ($urandom_range(3, 10)) begin
      j = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          sec = sess_start[j] + ((sess_end[j] > sess_start[j]) ?
                                 $urandom_range(0, sess_end[j] - sess_start[j]) : 0);
          text = sec_text(sec);
        end
        6, 7: begin
          case ($urandom_range(0, 3))
            0:       sec = sess_start[j] - 1;
            1:       sec = sess_start[j];
            2:       sec = sess_end[j];
            default: sec = sess_end[j] + 1;
          endcase
          text = sec_text(sec);
        end
        8: text = clock_text($urandom_range(0, 24), $urandom_range(0, 60),
                             $urandom_range(0, 60));
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            text = rand_text();
          end else begin
            // spoil one digit of a good time
            text = sec_text(rand_sec());
            p = $urandom_range(0, 5);
            p = p + p / 2;
            text[63 - 8 * p -: 8] = 8'($urandom);
          end
        end
      endcase
      send_item(OP_QUERY, rand_sec(), rand_sec(), text);
    end
    if ($urandom_range(0, 3) == 0) wait_drained();
  endtask

  initial begin : stimulus
    int counted;
    bit pressed;
    pressed = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, bad digits, plain and wrapped tables, full table
    send_item(OP_QUERY, 0, 0, clock_text(0, 0, 0));
    send_item(OP_QUERY, LAST_SEC, LAST_SEC, 64'h0);
    send_item(OP_QUERY, 0, LAST_SEC, '1);
    send_item(OP_UNUSED, rand_sec(), rand_sec(), rand_text());
    send_item(OP_APPEND, 5, 5, rand_text());
    send_item(OP_APPEND, 0, LAST_SEC, rand_text());
    send_item(OP_QUERY, 0, 0, clock_text(24, 60, 60));
    send_item(OP_CLEAR, 0, 0, 64'h0);
    send_item(OP_APPEND, 79200, 86399, rand_text());
    send_item(OP_APPEND, 3600, 7200, rand_text());
    send_item(OP_APPEND, 1000, 2000, rand_text());
    send_item(OP_APPEND, 10000, 20000, rand_text());
    send_item(OP_QUERY, 0, 0, clock_text(23, 0, 0));
    send_item(OP_QUERY, 0, 0, clock_text(1, 30, 0));
    send_item(OP_QUERY, 0, 0, clock_text(12, 0, 0));
    send_item(OP_APPEND, 30000, 40000, rand_text());
    send_item(OP_APPEND, 50000, 60000, rand_text());
    send_item(OP_APPEND, 60001, 61000, rand_text());
    send_item(OP_APPEND, 62000, 63000, rand_text());
    send_item(OP_APPEND, 64000, 65000, rand_text());
    send_item(OP_APPEND, 70000, 71000, rand_text());
    send_item(OP_QUERY, 0, 0, clock_text(17, 59, 60));
    send_item(OP_QUERY, 0, 0, clock_text(25, 0, 0));
    send_item(OP_QUERY, 0, 0, clock_text(0, 61, 70));
    send_item(OP_CLEAR, LAST_SEC, LAST_SEC, '1);
    wait_drained();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (!pressed && counted > 150) begin
        // output held off while input keeps coming, so the block backs up
        pressed       = 1'b1;
        hold_go      <= 1'b1;
        steady_sender = 1'b1;
        repeat (30) send_item(OP_QUERY, rand_sec(), rand_sec(), sec_text(rand_sec()));
        steady_sender = 1'b0;
      end else if ($urandom_range(0, 3) != 0) begin
        run_session();
      end else begin
        steady_sender = 1'b0;
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(0, 3)), rand_sec(), rand_sec(), rand_text());
      end
      counted = n_append + n_clear + n_query;
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d appends (%0d rejected), %0d clears, %0d lookups (%0d in session)",
             n_append, reject_count, n_clear, n_query, hit_count);
    $display("plus %0d unused-opcode transactions, a long output hold and drained pauses",
             n_ignored);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sesi_pkg.sv
sv/sesi_time_parse.sv
sv/sesi_cell.sv
sv/session_second_indexer_core.sv
test/session_lookup_checker.sv
test/session_second_indexer_core_test.sv
